// File: rtl/maze_dfs_explorer_core_assert.svh
// Assertion macros shared by the maze explorer RTL.
// Each macro samples on i_clk and is held off while i_rst_n is low.
`ifndef MAZE_DFS_EXPLORER_CORE_ASSERT_SVH
`define MAZE_DFS_EXPLORER_CORE_ASSERT_SVH

// Same-cycle implication
`define MDE_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (expr)) else $error(msg);

// Next-cycle implication
`define MDE_ASSERT_NXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expr)) else $error(msg);

`endif

// File: rtl/mde_pkg.sv
// Shared types and constants for the maze depth-first explorer.
// No dependencies.
package mde_pkg;

    localparam int unsigned HistDepthDef = 512;
    localparam int unsigned CoordBitsDef = 16;
    localparam int unsigned DistW        = 12;
    localparam int unsigned CellW        = 16;

    typedef enum logic [1:0] {
        HDG_N = 2'd0,
        HDG_E = 2'd1,
        HDG_S = 2'd2,
        HDG_W = 2'd3
    } t_heading;

    typedef enum logic [1:0] {
        TURN_NONE  = 2'd0,
        TURN_RIGHT = 2'd1,
        TURN_LEFT  = 2'd2,
        TURN_BACK  = 2'd3
    } t_turn;

    typedef enum logic [1:0] {
        STEP_EXPLORE   = 2'd0,
        STEP_BACKTRACK = 2'd1,
        STEP_COMPLETE  = 2'd2,
        STEP_HALTED    = 2'd3
    } t_step;

    typedef struct packed {
        logic                    ovf;
        t_heading                heading;
        t_step                   kind;
        t_turn                   turn;
        logic                    wall_w;
        logic                    wall_s;
        logic                    wall_e;
        logic                    wall_n;
        logic signed [CellW-1:0] cell_row;
        logic signed [CellW-1:0] cell_col;
    } t_result;

endpackage

// File: rtl/mde_out_fifo.sv
// Two-entry result queue that decouples the decision logic from the output stream.
// Depends on mde_pkg for the result item type.
module mde_out_fifo
    import mde_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_pop
);

    t_result    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       w_pop_go;

    assign w_pop_go = i_pop && (r_cnt != 2'd0);
    assign o_full   = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_data   = r_slot[r_rd_ptr];

    // Store the incoming item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop_go) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, w_pop_go})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/maze_dfs_explorer_core.sv
// Depth-first maze explorer: one input item per cell (left/front/right distances
// and a front-wall flag) gives one result item (cell, wall map, turn, step kind,
// new heading, overflow). A backtrack holds off the next input item while
// the popped position comes out of the history memory through its
// registered read port. Results are registered into a two-entry buffer.
// No clearing pass after reset. Depends on mde_pkg, mde_out_fifo and
// maze_dfs_explorer_core_assert.svh.
`include "maze_dfs_explorer_core_assert.svh"

module maze_dfs_explorer_core
    import mde_pkg::*;
#(
    parameter int unsigned HIST_DEPTH = HistDepthDef,
    parameter int unsigned COORD_BITS = CoordBitsDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Threshold register write
    input  logic             i_cfg_wr_en,
    input  logic [DistW-1:0] i_cfg_wr_data,
    // Input item stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [11:0] dist_left, [23:12] dist_front, [35:24] dist_right, [39:36] zero
    input  logic [39:0]      s_axis_tdata,
    // [0] front_confirmed
    input  logic [0:0]       s_axis_tuser,
    // Result item stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [15:0] cell_col, [31:16] cell_row, [32] wall_north, [33] wall_east,
    // [34] wall_south, [35] wall_west, [37:36] turn_cmd, [39:38] new_heading,
    // [40] stack_overflow, [47:41] zero
    output logic [47:0]      m_axis_tdata,
    // [1:0] step_kind
    output logic [1:0]       m_axis_tuser
);

    localparam int unsigned AddrW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int unsigned CntW  = $clog2(HIST_DEPTH + 1);
    localparam int unsigned EntW  = 2 * COORD_BITS;

    // State
    logic [DistW-1:0]      r_thr;
    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    t_heading              r_hdg;
    logic [CntW-1:0]       r_hist_cnt;
    logic                  r_finished;
    logic                  r_pop_pending;
    logic [EntW-1:0]       r_hist [HIST_DEPTH];
    logic [EntW-1:0]       r_rd_data;

    // Decision signals
    logic                  w_acc;
    logic                  w_fifo_full;
    logic signed [DistW:0] w_thr;
    logic signed [DistW:0] w_dl;
    logic signed [DistW:0] w_df_raw;
    logic signed [DistW:0] w_df;
    logic signed [DistW:0] w_dr;
    logic signed [DistW:0] w_best;
    t_heading              w_best_h;
    t_turn                 w_best_turn;
    t_heading              w_hl;
    t_heading              w_hr;
    t_heading              w_hb;
    logic [3:0]            w_walls;
    logic                  w_explore;
    logic                  w_empty;
    logic                  w_full;
    logic                  w_push;
    logic                  w_pop;
    logic [COORD_BITS-1:0] w_mv_col;
    logic [COORD_BITS-1:0] w_mv_row;
    logic signed [COORD_BITS-1:0] w_col_s;
    logic signed [COORD_BITS-1:0] w_row_s;
    t_result               w_res;
    t_result               w_out;

    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !w_fifo_full && !r_pop_pending;

    // Field extraction and confirmed-front clamp
    assign w_thr    = {1'b0, r_thr};
    assign w_dl     = {1'b0, s_axis_tdata[11:0]};
    assign w_df_raw = {1'b0, s_axis_tdata[23:12]};
    assign w_dr     = {1'b0, s_axis_tdata[35:24]};
    assign w_df     = (s_axis_tuser[0] && (w_df_raw >= w_thr)) ? (w_thr - 13'sd1) : w_df_raw;

    // Relative headings
    assign w_hl = t_heading'(r_hdg + 2'd3);
    assign w_hr = t_heading'(r_hdg + 2'd1);
    assign w_hb = t_heading'(r_hdg + 2'd2);

    assign w_empty = (r_hist_cnt == '0);
    assign w_full  = (r_hist_cnt == CntW'(HIST_DEPTH));

    // Wall map in compass order
    always_comb begin
        w_walls        = 4'b0000;
        w_walls[w_hl]  = (w_dl < w_thr);
        w_walls[r_hdg] = (w_df < w_thr);
        w_walls[w_hr]  = (w_dr < w_thr);
        w_walls[w_hb]  = w_empty;
    end

    // Pick the widest opening, earlier side wins ties
    always_comb begin
        w_best      = w_dl;
        w_best_h    = w_hl;
        w_best_turn = TURN_LEFT;
        if (w_df > w_best) begin
            w_best      = w_df;
            w_best_h    = r_hdg;
            w_best_turn = TURN_NONE;
        end
        if (w_dr > w_best) begin
            w_best      = w_dr;
            w_best_h    = w_hr;
            w_best_turn = TURN_RIGHT;
        end
    end

    assign w_explore = (w_best >= w_thr);
    assign w_push    = w_acc && !r_finished && w_explore && !w_full;
    assign w_pop     = w_acc && !r_finished && !w_explore && !w_empty;

    // Step one cell toward the chosen heading
    always_comb begin
        w_mv_col = r_col;
        w_mv_row = r_row;
        unique case (w_best_h)
            HDG_N: w_mv_row = r_row - COORD_BITS'(1);
            HDG_E: w_mv_col = r_col + COORD_BITS'(1);
            HDG_S: w_mv_row = r_row + COORD_BITS'(1);
            HDG_W: w_mv_col = r_col - COORD_BITS'(1);
            default: w_mv_col = r_col;
        endcase
    end

    // Build the result item
    assign w_col_s = r_col;
    assign w_row_s = r_row;
    always_comb begin
        w_res.cell_col = CellW'(w_col_s);
        w_res.cell_row = CellW'(w_row_s);
        w_res.wall_n   = 1'b0;
        w_res.wall_e   = 1'b0;
        w_res.wall_s   = 1'b0;
        w_res.wall_w   = 1'b0;
        w_res.turn     = TURN_NONE;
        w_res.kind     = STEP_HALTED;
        w_res.heading  = r_hdg;
        w_res.ovf      = 1'b0;
        if (!r_finished) begin
            w_res.wall_n = w_walls[HDG_N];
            w_res.wall_e = w_walls[HDG_E];
            w_res.wall_s = w_walls[HDG_S];
            w_res.wall_w = w_walls[HDG_W];
            if (w_explore) begin
                w_res.turn    = w_best_turn;
                w_res.kind    = STEP_EXPLORE;
                w_res.heading = w_best_h;
                w_res.ovf     = w_full;
            end else if (w_empty) begin
                w_res.kind = STEP_COMPLETE;
            end else begin
                w_res.turn    = TURN_BACK;
                w_res.kind    = STEP_BACKTRACK;
                w_res.heading = w_hb;
            end
        end
    end

    // History memory: write on push, registered read on pop
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_hist[r_hist_cnt[AddrW-1:0]] <= {r_col, r_row};
        end
        if (w_pop) begin
            r_rd_data <= r_hist[AddrW'(r_hist_cnt - CntW'(1))];
        end
    end

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= DistW'(180);
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // Position, heading and stack bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_row         <= '0;
            r_hdg         <= HDG_N;
            r_hist_cnt    <= '0;
            r_finished    <= 1'b0;
            r_pop_pending <= 1'b0;
        end else begin
            r_pop_pending <= w_pop;
            if (r_pop_pending) begin
                r_col <= r_rd_data[EntW-1:COORD_BITS];
                r_row <= r_rd_data[COORD_BITS-1:0];
            end
            if (w_acc && !r_finished) begin
                if (w_explore) begin
                    r_hdg <= w_best_h;
                    r_col <= w_mv_col;
                    r_row <= w_mv_row;
                    if (!w_full) begin
                        r_hist_cnt <= r_hist_cnt + CntW'(1);
                    end
                end else if (w_empty) begin
                    r_finished <= 1'b1;
                end else begin
                    r_hdg      <= w_hb;
                    r_hist_cnt <= r_hist_cnt - CntW'(1);
                end
            end
        end
    end

    // Result queue
    mde_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_acc),
        .i_data  (w_res),
        .o_full  (w_fifo_full),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out),
        .i_pop   (m_axis_tready)
    );

    assign m_axis_tdata = {7'b0, w_out.ovf, w_out.heading, w_out.turn,
                           w_out.wall_w, w_out.wall_s, w_out.wall_e, w_out.wall_n,
                           w_out.cell_row, w_out.cell_col};
    assign m_axis_tuser = w_out.kind;

    `MDE_ASSERT_IMP(a_pop_blocks_input, r_pop_pending, !s_axis_tready,
        "item accepted while popped position still in flight")
    `MDE_ASSERT_NXT(a_pop_sets_pending, w_pop, r_pop_pending,
        "backtrack did not schedule a position load")
    `MDE_ASSERT_NXT(a_finished_sticks, r_finished, r_finished,
        "finished flag cleared without reset")
    `MDE_ASSERT_NXT(a_push_counts, w_push, r_hist_cnt == $past(r_hist_cnt) + CntW'(1),
        "history count did not advance on push")
    `MDE_ASSERT_IMP(a_count_bound, 1'b1, r_hist_cnt <= CntW'(HIST_DEPTH),
        "history count above depth")

endmodule
